/* src/assert_macros.svh */
// Assertion macros shared by the sprite DMA sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sdma_pkg.sv */
// Types, constants and codes of the sprite DMA sequencer.
`timescale 1ns / 1ps
`default_nettype none

package sdma_pkg;

  localparam int CHANNELS   = 8;
  localparam int CH_W       = 3;
  localparam int CH_CNT_W   = CH_W + 1;
  localparam int LINE_W     = 9;
  localparam int PTR_W      = 21;
  localparam int VALUE_W    = 16;
  localparam int REG_ADDR_W = 9;
  localparam int CFG_DATA_W = 9;

  // Sprite register offsets, channel stride 8 bytes
  localparam logic [REG_ADDR_W-1:0] REG_POS  = REG_ADDR_W'(12'h140);
  localparam logic [REG_ADDR_W-1:0] REG_CTL  = REG_ADDR_W'(12'h142);
  localparam logic [REG_ADDR_W-1:0] REG_DATA = REG_ADDR_W'(12'h144);
  localparam logic [REG_ADDR_W-1:0] REG_DATB = REG_ADDR_W'(12'h146);
  localparam int REG_STRIDE_SH = 3;

  localparam int PTR_STEP = 2;
  localparam logic [LINE_W-1:0] VSTART_HI_MASK = LINE_W'(12'h100);
  localparam logic [LINE_W-1:0] VSTART_LO_MASK = LINE_W'(12'h0ff);
  localparam logic [LINE_W-1:0] VBLANK_END_RST = LINE_W'(26);

  typedef enum logic [2:0] {
    MODE_START_LINE = 3'd0,
    MODE_CHECK      = 3'd1,
    MODE_BUS_WORD   = 3'd2,
    MODE_VSTART_LO  = 3'd3,
    MODE_VSTART_HI  = 3'd4,
    MODE_VSTOP      = 3'd5,
    MODE_POINTER    = 3'd6,
    MODE_CLEAR      = 3'd7
  } mode_e;

  typedef enum logic [0:0] {
    CFG_DMA_ENABLE  = 1'b0,
    CFG_VBLANK_END  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    cfg_reg_e              index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_item_t;

  typedef struct packed {
    mode_e              mode;
    logic [LINE_W-1:0]  line;
    logic [CH_W-1:0]    channel;
    logic [VALUE_W-1:0] value;
    logic [PTR_W-1:0]   pointer_value;
  } in_item_t;

  typedef struct packed {
    logic                  fetch_valid;
    logic [PTR_W-1:0]      fetch_address;
    logic [CH_W-1:0]       fetch_channel;
    logic                  reg_write_valid;
    logic [REG_ADDR_W-1:0] reg_address;
    logic [VALUE_W-1:0]    reg_value;
    logic                  check_next;
    logic                  sequence_stopped;
    logic [CH_W-1:0]       active_channel;
  } out_item_t;

  // One channel's stored state
  typedef struct packed {
    logic [LINE_W-1:0] vstart;
    logic [LINE_W-1:0] vstop;
    logic [PTR_W-1:0]  ptr;
  } chan_row_t;

  typedef struct packed {
    logic            re;
    logic [CH_W-1:0] raddr;
    logic            we;
    logic [CH_W-1:0] waddr;
    chan_row_t       wrow;
  } mem_req_t;

endpackage

`default_nettype wire

/* src/sdma_stream_if.sv */
// Valid/ready stream interface used by all channels of the sequencer.
`timescale 1ns / 1ps
`default_nettype none

interface sdma_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/sdma_chan_mem.sv */
// Per-channel state memory: sync read, entry valid bits and write-to-read bypass.
`timescale 1ns / 1ps
`default_nettype none

module sdma_chan_mem (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sdma_pkg::mem_req_t req_i,
  output sdma_pkg::chan_row_t     row_o
);

  sdma_pkg::chan_row_t                 mem_q [sdma_pkg::CHANNELS];
  sdma_pkg::chan_row_t                 rdata_q;
  sdma_pkg::chan_row_t                 fwd_row_q;
  logic [sdma_pkg::CHANNELS-1:0]       ent_valid_q;
  logic                                rvalid_q;
  logic                                fwd_q;
  logic                                hit;

  // Same-entry write in the read cycle: memory returns old data, so bypass
  assign hit = req_i.re && req_i.we && (req_i.waddr == req_i.raddr);

  // Storage array and registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wrow;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
    if (hit) begin
      fwd_row_q <= req_i.wrow;
    end
  end

  // Entry valid bits stand in for the zero reset of the array
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
      rvalid_q    <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      if (req_i.we) begin
        ent_valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= ent_valid_q[req_i.raddr];
        fwd_q    <= hit;
      end
    end
  end

  assign row_o = fwd_q ? fwd_row_q : (rvalid_q ? rdata_q : '0);

endmodule

`default_nettype wire

/* src/sprite_dma_sequencer.sv */
// Top level of the eight-channel sprite DMA sequencer.
// Usage:
//   in_i  : event beats (start line, check, bus word, set events, clear).
//   out_o : exactly one result beat per event, in event order.
//   cfg_i : register writes (dma_enable, vblank_end_line); always ready;
//           the user must write only while the block is idle; not enforced.
// Pipeline: an accepted event is registered in the execute stage, then its
//   result in the output register, from which its result beat is taken.
// Throughput: one event per cycle unless the output stalls. The check
//   compare on the row just read decides the channel index, which addresses
//   the next memory read in the same cycle; that path sets the cycle time.
// Reset: channel index 0, all read and first-word flags clear, dma off,
//   vblank_end_line 26; per-entry valid bits make the channel memory read
//   zero until written, so there is no clearing pass.
// Stall: when the sink holds ready low, the output register keeps its beat,
//   one further event waits in the execute stage, and in_i.ready drops.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sprite_dma_sequencer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  sdma_stream_if.sink        in_i,
  sdma_stream_if.source      out_o,
  sdma_stream_if.sink        cfg_i
);

  // Configuration registers
  logic                            dma_q;
  logic [sdma_pkg::LINE_W-1:0]     vbe_q;

  // Sequencer state
  logic [sdma_pkg::CH_W-1:0]       cc_q, cc_d;
  logic [sdma_pkg::CHANNELS-1:0]   rd_q, rd_d;
  logic [sdma_pkg::CHANNELS-1:0]   rc_q, rc_d;
  logic [sdma_pkg::CHANNELS-1:0]   fw_q, fw_d;

  // Execute stage and output register
  logic                            s1_valid_q;
  sdma_pkg::in_item_t              s1_item_q;
  logic                            out_valid_q;
  sdma_pkg::out_item_t             out_data_q;
  sdma_pkg::out_item_t             res;

  logic                            in_fire, s1_fire, in_ready;
  sdma_pkg::mem_req_t              mem_req;
  sdma_pkg::chan_row_t             row;
  sdma_pkg::chan_row_t             wrow;
  logic                            wr_en;
  logic                            set_ev;
  logic                            in_set_ev;

  logic [sdma_pkg::LINE_W:0]       line_p1;
  logic [sdma_pkg::LINE_W:0]       vbe_ext;
  logic [sdma_pkg::CH_CNT_W-1:0]   cc_inc;
  logic                            adv_more;
  logic                            chan_ok;
  logic                            hit_ctl;
  logic                            rd_n, rc_n;
  logic [sdma_pkg::REG_ADDR_W-1:0] ch_off;
  logic [sdma_pkg::PTR_W-1:0]      ptr_inc;
  logic [sdma_pkg::LINE_W-1:0]     val_line;

  assign s1_fire  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || s1_fire;
  assign in_fire  = in_i.valid && in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Configuration write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dma_q <= 1'b0;
      vbe_q <= sdma_pkg::VBLANK_END_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        sdma_pkg::CFG_DMA_ENABLE: dma_q <= cfg_i.data.value[0];
        sdma_pkg::CFG_VBLANK_END: vbe_q <= cfg_i.data.value[sdma_pkg::LINE_W-1:0];
        default:                  dma_q <= dma_q;
      endcase
    end
  end

  // Shared terms of the execute stage
  assign line_p1  = {1'b0, s1_item_q.line} + (sdma_pkg::LINE_W + 1)'(1);
  assign vbe_ext  = {1'b0, vbe_q};
  assign cc_inc   = {1'b0, cc_q} + sdma_pkg::CH_CNT_W'(1);
  assign adv_more = cc_inc < sdma_pkg::CH_CNT_W'(sdma_pkg::CHANNELS);
  assign chan_ok  = {1'b0, s1_item_q.channel} < sdma_pkg::CH_CNT_W'(sdma_pkg::CHANNELS);
  assign hit_ctl  = (line_p1 == vbe_ext) || (s1_item_q.line == row.vstop);
  assign ch_off   = sdma_pkg::REG_ADDR_W'(cc_q) << sdma_pkg::REG_STRIDE_SH;
  assign ptr_inc  = row.ptr + sdma_pkg::PTR_W'(sdma_pkg::PTR_STEP);
  assign val_line = s1_item_q.value[sdma_pkg::LINE_W-1:0];
  assign set_ev   = (s1_item_q.mode == sdma_pkg::MODE_VSTART_LO) ||
                    (s1_item_q.mode == sdma_pkg::MODE_VSTART_HI) ||
                    (s1_item_q.mode == sdma_pkg::MODE_VSTOP)     ||
                    (s1_item_q.mode == sdma_pkg::MODE_POINTER);

  // Check decision: control read wins over data read
  always_comb begin
    rd_n = rd_q[cc_q];
    rc_n = 1'b1;
    if (hit_ctl) begin
      rd_n = 1'b0;
    end else begin
      rc_n = 1'b0;
      if (s1_item_q.line == row.vstart) begin
        rd_n = 1'b1;
      end
    end
  end

  // Execute stage: next state, row write-back and result
  always_comb begin
    cc_d  = cc_q;
    rd_d  = rd_q;
    rc_d  = rc_q;
    fw_d  = fw_q;
    res   = '0;
    wr_en = 1'b0;
    wrow  = row;
    if (s1_valid_q) begin
      unique case (s1_item_q.mode)
        sdma_pkg::MODE_START_LINE: begin
          if (line_p1 < vbe_ext) begin
            res.sequence_stopped = 1'b1;
          end else begin
            cc_d           = '0;
            res.check_next = 1'b1;
          end
        end
        sdma_pkg::MODE_CHECK: begin
          if (!dma_q) begin
            res.sequence_stopped = 1'b1;
          end else begin
            rd_d[cc_q] = rd_n;
            rc_d[cc_q] = rc_n;
            if (rd_n || rc_n) begin
              fw_d[cc_q]        = 1'b1;
              res.fetch_valid   = 1'b1;
              res.fetch_address = row.ptr;
              res.fetch_channel = cc_q;
            end else if (adv_more) begin
              cc_d           = cc_inc[sdma_pkg::CH_W-1:0];
              res.check_next = 1'b1;
            end else begin
              res.sequence_stopped = 1'b1;
            end
          end
        end
        sdma_pkg::MODE_BUS_WORD: begin
          if (rd_q[cc_q] || rc_q[cc_q]) begin
            wr_en               = 1'b1;
            wrow.ptr            = ptr_inc;
            res.reg_write_valid = 1'b1;
            res.reg_value       = s1_item_q.value;
            if (fw_q[cc_q]) begin
              fw_d[cc_q]        = 1'b0;
              res.reg_address   = (rd_q[cc_q] ? sdma_pkg::REG_DATB : sdma_pkg::REG_POS)
                                  + ch_off;
              res.fetch_valid   = 1'b1;
              res.fetch_address = ptr_inc;
              res.fetch_channel = cc_q;
            end else begin
              res.reg_address = (rd_q[cc_q] ? sdma_pkg::REG_DATA : sdma_pkg::REG_CTL)
                                + ch_off;
              if (adv_more) begin
                cc_d           = cc_inc[sdma_pkg::CH_W-1:0];
                res.check_next = 1'b1;
              end else begin
                res.sequence_stopped = 1'b1;
              end
            end
          end
        end
        sdma_pkg::MODE_VSTART_LO: begin
          wr_en       = chan_ok;
          wrow.vstart = (row.vstart & sdma_pkg::VSTART_HI_MASK) | val_line;
        end
        sdma_pkg::MODE_VSTART_HI: begin
          wr_en       = chan_ok;
          wrow.vstart = val_line | (row.vstart & sdma_pkg::VSTART_LO_MASK);
        end
        sdma_pkg::MODE_VSTOP: begin
          wr_en      = chan_ok;
          wrow.vstop = val_line;
        end
        sdma_pkg::MODE_POINTER: begin
          wr_en    = chan_ok;
          wrow.ptr = s1_item_q.pointer_value;
        end
        sdma_pkg::MODE_CLEAR: begin
          rd_d = '0;
          rc_d = '0;
        end
        default: begin
          res = '0;
        end
      endcase
    end
    res.active_channel = cc_d;
  end

  // Memory request: set events address their own channel, the rest the
  // channel left by the event now executing
  assign in_set_ev = (in_i.data.mode == sdma_pkg::MODE_VSTART_LO) ||
                     (in_i.data.mode == sdma_pkg::MODE_VSTART_HI) ||
                     (in_i.data.mode == sdma_pkg::MODE_VSTOP)     ||
                     (in_i.data.mode == sdma_pkg::MODE_POINTER);

  always_comb begin
    mem_req.re    = in_fire;
    mem_req.raddr = in_set_ev ? in_i.data.channel : cc_d;
    mem_req.we    = s1_fire && wr_en;
    mem_req.waddr = set_ev ? s1_item_q.channel : cc_q;
    mem_req.wrow  = wrow;
  end

  sdma_chan_mem u_chan_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .row_o  (row)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q        <= '0;
      rd_q        <= '0;
      rc_q        <= '0;
      fw_q        <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_fire) begin
        cc_q <= cc_d;
        rd_q <= rd_d;
        rc_q <= rc_d;
        fw_q <= fw_d;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_i.data;
    end
    if (s1_fire) begin
      out_data_q <= res;
    end
  end

  `ASSERT_ALWAYS(a_next_xor_stop, !(out_valid_q && out_data_q.check_next && out_data_q.sequence_stopped), "check_next and sequence_stopped both set")
  `ASSERT_IMPL(a_fetch_not_stopped, out_valid_q && out_data_q.fetch_valid, !out_data_q.sequence_stopped, "fetch on a stopped line")
  `ASSERT_NEXT(a_exec_hold, s1_valid_q && !s1_fire, s1_valid_q && $stable(s1_item_q), "stalled event lost")
  `ASSERT_NEXT(a_accept_exec, in_fire, s1_valid_q, "accepted event missing in execute stage")

endmodule

`default_nettype wire
